### src/mchm_pkg.sv
// Shared constants, types and age-tracking steps for the heartbeat monitor.
package mchm_pkg;

  localparam int CHANNEL_COUNT    = 5;
  localparam int TICKS_PER_SECOND = 1000;

  localparam int WORD_W     = 32;
  localparam int CH_W       = 3;
  localparam int OP_W       = 2;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CRIT_FIRST = 1;
  localparam int CRIT_COUNT = 4;

  localparam int MS_PER_SECOND = 1000;

  // Remainder of scaled/TICKS_PER_SECOND lives in REM_W bits.
  localparam int REM_W = $clog2(TICKS_PER_SECOND + 1);

  localparam longint unsigned WORD_MOD = 64'd1 << WORD_W;

  // Per tick, scaled grows by MS_PER_SECOND = QUO_STEP*TPS + REM_STEP.
  // A wrap of scaled removes 2^32 = WRAP_QUO*TPS + WRAP_REM.
  localparam logic [WORD_W-1:0] MS_STEP  = WORD_W'(MS_PER_SECOND);
  localparam logic [WORD_W-1:0] QUO_STEP = WORD_W'(MS_PER_SECOND / TICKS_PER_SECOND);
  localparam logic [REM_W:0]    REM_STEP = (REM_W+1)'(MS_PER_SECOND % TICKS_PER_SECOND);
  localparam logic [WORD_W-1:0] WRAP_QUO = WORD_W'(WORD_MOD / TICKS_PER_SECOND);
  localparam logic [REM_W:0]    WRAP_REM = (REM_W+1)'(WORD_MOD % TICKS_PER_SECOND);
  localparam logic [REM_W:0]    TPS_WIDE = (REM_W+1)'(TICKS_PER_SECOND);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET [CRIT_COUNT] = '{
    LIMIT_W'(200), LIMIT_W'(200), LIMIT_W'(500), LIMIT_W'(500)
  };

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_BEAT  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] last;
    logic [WORD_W-1:0] age;
    logic              beaten;
  } chan_stat_t;

endpackage

### src/mchm_chan.sv
// One channel: beat count, last beat tick and an incrementally tracked age.
module mchm_chan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick_en,
  input  logic                       beat_en,
  input  logic [mchm_pkg::WORD_W-1:0] tick_now,
  output mchm_pkg::chan_stat_t       stat_next
);
  import mchm_pkg::*;

  logic [WORD_W-1:0] count, count_next;
  logic [WORD_W-1:0] last, last_next;
  // scaled = (tick_now - last) * 1000 mod 2^32, kept as quo*TPS + rem
  logic [WORD_W-1:0] scaled, scaled_next;
  logic [WORD_W-1:0] quo, quo_next;
  logic [REM_W-1:0]  rem, rem_next;

  logic [WORD_W:0]   sum_wide;
  logic              wrap;
  logic [REM_W:0]    rem_a, rem_b, rem_c;
  logic              carry;
  logic              borrow;
  logic [WORD_W-1:0] quo_tick;

  always_comb begin
    sum_wide = {1'b0, scaled} + {1'b0, MS_STEP};
    wrap     = sum_wide[WORD_W];

    rem_a = {1'b0, rem} + REM_STEP;
    carry = (rem_a >= TPS_WIDE);
    rem_b = carry ? rem_a - TPS_WIDE : rem_a;

    borrow = wrap && (rem_b < WRAP_REM);
    if (!wrap) begin
      rem_c = rem_b;
    end else if (borrow) begin
      rem_c = rem_b + TPS_WIDE - WRAP_REM;
    end else begin
      rem_c = rem_b - WRAP_REM;
    end

    quo_tick = quo + QUO_STEP + WORD_W'(carry);
    if (wrap) begin
      quo_tick = quo_tick - WRAP_QUO - WORD_W'(borrow);
    end

    count_next  = count;
    last_next   = last;
    scaled_next = scaled;
    quo_next    = quo;
    rem_next    = rem;
    if (beat_en) begin
      count_next  = count + WORD_W'(1);
      last_next   = tick_now;
      scaled_next = '0;
      quo_next    = '0;
      rem_next    = '0;
    end else if (tick_en) begin
      scaled_next = sum_wide[WORD_W-1:0];
      quo_next    = quo_tick;
      rem_next    = rem_c[REM_W-1:0];
    end

    stat_next.count  = count_next;
    stat_next.last   = last_next;
    stat_next.age    = quo_next;
    stat_next.beaten = (last_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      last   <= '0;
      scaled <= '0;
      quo    <= '0;
      rem    <= '0;
    end else begin
      count  <= count_next;
      last   <= last_next;
      scaled <= scaled_next;
      quo    <= quo_next;
      rem    <= rem_next;
    end
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, rem} < TPS_WIDE)
    else $error("age remainder out of range");

  a_beat_clears_age: assert property (@(posedge clk) disable iff (rst)
    beat_en |=> (quo == '0) && (last == $past(tick_now)))
    else $error("beat did not restart age");
`endif

endmodule

### src/mchm_report.sv
// Result selection, alive checks and the output register with skid stage.
module mchm_report (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  output logic                         in_ready,
  input  logic [mchm_pkg::CH_W-1:0]    channel,
  input  logic [mchm_pkg::WORD_W-1:0]  age_threshold,
  input  mchm_pkg::chan_stat_t         stats [mchm_pkg::CHANNEL_COUNT],
  input  logic [mchm_pkg::LIMIT_W-1:0] limits [mchm_pkg::CRIT_COUNT],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mchm_pkg::WORD_W-1:0]  beat_count,
  output logic [mchm_pkg::WORD_W-1:0]  last_tick,
  output logic [mchm_pkg::WORD_W-1:0]  age_ms,
  output logic                         alive,
  output logic                         all_critical_alive
);
  import mchm_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] last;
    logic [WORD_W-1:0] age;
    logic              alive;
    logic              crit;
  } result_t;

  chan_stat_t sel;
  logic       sel_ok;
  result_t    res;
  result_t    skid;
  logic       skid_full;
  logic       crit;

  always_comb begin
    sel    = '0;
    sel_ok = 1'b0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (channel == CH_W'(i)) begin
        sel    = stats[i];
        sel_ok = 1'b1;
      end
    end

    crit = 1'b1;
    for (int i = 0; i < CRIT_COUNT; i++) begin
      if (!stats[CRIT_FIRST + i].beaten ||
          (stats[CRIT_FIRST + i].age > {{(WORD_W-LIMIT_W){1'b0}}, limits[i]})) begin
        crit = 1'b0;
      end
    end

    res.count = sel_ok ? sel.count : '0;
    res.last  = sel_ok ? sel.last : '0;
    res.age   = (sel_ok && sel.beaten) ? sel.age : '1;
    res.alive = sel_ok && sel.beaten && (sel.age <= age_threshold);
    res.crit  = crit;
  end

  assign in_ready = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_fire) begin
        skid_full <= 1'b1;
      end
    end else if (skid_full) begin
      out_valid <= 1'b1;
      skid_full <= 1'b0;
    end else begin
      out_valid <= in_fire;
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (in_fire) begin
        skid <= res;
      end
    end else if (skid_full) begin
      beat_count         <= skid.count;
      last_tick          <= skid.last;
      age_ms             <= skid.age;
      alive              <= skid.alive;
      all_critical_alive <= skid.crit;
    end else if (in_fire) begin
      beat_count         <= res.count;
      last_tick          <= res.last;
      age_ms             <= res.age;
      alive              <= res.alive;
      all_critical_alive <= res.crit;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid beat held with empty output");

  a_alive_needs_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && alive |-> (last_tick != '0) && (age_ms != '1))
    else $error("alive reported for never-beaten channel");
`endif

endmodule

### src/multi_channel_heartbeat_monitor.sv
// Top level: tick counter, limit registers, channel trackers and result stage.
// Each result is registered in the output register, or in the skid register
// while the output is stalled. Throughput: one item per cycle while the skid
// is empty; ages update per tick with adds only and need no divider.
// A two-deep output stage (result register plus skid) keeps input open while
// one beat is stalled. Reset (rst, synchronous) zeroes ticks, counts and
// stamps and loads the limits with 200/200/500/500 ms.
module multi_channel_heartbeat_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mchm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mchm_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mchm_pkg::OP_W-1:0]      opcode,
  input  logic [mchm_pkg::CH_W-1:0]      channel,
  input  logic [mchm_pkg::WORD_W-1:0]    age_threshold,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mchm_pkg::WORD_W-1:0]    beat_count,
  output logic [mchm_pkg::WORD_W-1:0]    last_tick,
  output logic [mchm_pkg::WORD_W-1:0]    age_ms,
  output logic                           alive,
  output logic                           all_critical_alive
);
  import mchm_pkg::*;

  logic              in_fire;
  logic              tick_en;
  logic              beat_op;
  logic [WORD_W-1:0] tick_now, tick_now_next;
  logic [LIMIT_W-1:0] limits [CRIT_COUNT];
  chan_stat_t        stats [CHANNEL_COUNT];

  assign in_fire       = in_valid && in_ready;
  assign tick_en       = in_fire && (opcode == OP_TICK);
  assign beat_op       = in_fire && (opcode == OP_BEAT);
  assign tick_now_next = tick_en ? tick_now + WORD_W'(1) : tick_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now <= '0;
    end else begin
      tick_now <= tick_now_next;
    end
  end

  // register index equals limit slot
  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= LIMIT_RESET;
    end else if (cfg_we) begin
      limits[cfg_index] <= cfg_data;
    end
  end

  for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_chan
    mchm_chan u_chan (
      .clk       (clk),
      .rst       (rst),
      .tick_en   (tick_en),
      .beat_en   (beat_op && (channel == CH_W'(i))),
      .tick_now  (tick_now),
      .stat_next (stats[i])
    );
  end

  mchm_report u_report (
    .clk                (clk),
    .rst                (rst),
    .in_fire            (in_fire),
    .in_ready           (in_ready),
    .channel            (channel),
    .age_threshold      (age_threshold),
    .stats              (stats),
    .limits             (limits),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .beat_count         (beat_count),
    .last_tick          (last_tick),
    .age_ms             (age_ms),
    .alive              (alive),
    .all_critical_alive (all_critical_alive)
  );

`ifndef SYNTHESIS
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    tick_en |=> tick_now == $past(tick_now) + WORD_W'(1))
    else $error("tick counter did not advance");

  a_tick_hold: assert property (@(posedge clk) disable iff (rst)
    !tick_en |=> $stable(tick_now))
    else $error("tick counter moved without a tick beat");
`endif

endmodule

### test/multi_channel_heartbeat_monitor_tb.sv
// Self-checking testbench for the multi-channel heartbeat monitor.
`timescale 1ns / 1ps

module multi_channel_heartbeat_monitor_tb;
  import mchm_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MOTOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HOST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_DEBUG  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_STATUS = 2'd3;

  localparam logic [WORD_W-1:0] AGE_NEVER = '1;
  localparam int PHASE_ITEMS = 80;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   ch;
    logic [WORD_W-1:0] max_age;
  } hb_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] last;
    logic [WORD_W-1:0] age;
    logic              alive;
    logic              crit;
  } hb_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      opcode = '0;
  logic [CH_W-1:0]      channel = '0;
  logic [WORD_W-1:0]    age_threshold = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    beat_count;
  logic [WORD_W-1:0]    last_tick;
  logic [WORD_W-1:0]    age_ms;
  logic                 alive;
  logic                 all_critical_alive;

  multi_channel_heartbeat_monitor dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .opcode             (opcode),
    .channel            (channel),
    .age_threshold      (age_threshold),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .beat_count         (beat_count),
    .last_tick          (last_tick),
    .age_ms             (age_ms),
    .alive              (alive),
    .all_critical_alive (all_critical_alive)
  );

  always #6 clk = ~clk;

  // shadow state of the monitor
  logic [WORD_W-1:0]  tick_count = '0;
  logic [WORD_W-1:0]  ch_beats [CHANNEL_COUNT];
  logic [WORD_W-1:0]  ch_stamp [CHANNEL_COUNT];
  logic [LIMIT_W-1:0] crit_limit [CRIT_COUNT];

  hb_item_t   pending_items [$];
  hb_report_t expected_reports [$];

  int error_count = 0;
  int items_sent = 0;
  int reports_seen = 0;
  int alive_seen = 0;
  int crit_seen = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_cycle = 0;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    error_count++;
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  function automatic logic [WORD_W-1:0] ch_age(input int unsigned ch);
    logic [WORD_W-1:0]   diff;
    logic [2*WORD_W-1:0] scaled;
    if (ch >= CHANNEL_COUNT || ch_stamp[ch] == '0) return AGE_NEVER;
    diff   = tick_count - ch_stamp[ch];
    scaled = {{WORD_W{1'b0}}, diff} * (2*WORD_W)'(MS_PER_SECOND);
    return scaled[WORD_W-1:0] / WORD_W'(TICKS_PER_SECOND);
  endfunction

  function automatic logic ch_alive(input int unsigned ch, input logic [WORD_W-1:0] thr);
    if (ch >= CHANNEL_COUNT || ch_stamp[ch] == '0) return 1'b0;
    return ch_age(ch) <= thr;
  endfunction

  // apply one accepted item to the shadow state and queue its report
  task automatic heartbeat_step(input hb_item_t it);
    hb_report_t r;
    logic       known_ch;
    known_ch = (it.ch < CHANNEL_COUNT);
    if (it.op == OP_TICK) begin
      tick_count = tick_count + 1'b1;
    end else if (it.op == OP_BEAT && known_ch) begin
      ch_beats[it.ch] = ch_beats[it.ch] + 1'b1;
      ch_stamp[it.ch] = tick_count;
    end
    r.crit = 1'b1;
    for (int c = CRIT_FIRST; c < CRIT_FIRST + CRIT_COUNT; c++)
      if (!ch_alive(c, WORD_W'(crit_limit[c - CRIT_FIRST]))) r.crit = 1'b0;
    r.count = known_ch ? ch_beats[it.ch] : '0;
    r.last  = known_ch ? ch_stamp[it.ch] : '0;
    r.age   = ch_age(it.ch);
    r.alive = ch_alive(it.ch, it.max_age);
    expected_reports.push_back(r);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    logic fire;
    logic nxt_valid;
    fire = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        heartbeat_step(pending_items[0]);
        void'(pending_items.pop_front());
        items_sent++;
      end
      if (!in_valid || fire) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          nxt_valid     = 1'b1;
          opcode        <= pending_items[0].op;
          channel       <= pending_items[0].ch;
          age_threshold <= pending_items[0].max_age;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // receiver: stall pattern cycles through always-ready, random and periodic
  always @(posedge clk) begin
    hb_report_t want;
    if (!rst) begin
      rx_cycle++;
      case ((rx_cycle / 97) % 3)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_ready <= (rx_cycle % 4 != 1);
        end
      endcase
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected beat", beat_count, '0);
        end else begin
          want = expected_reports.pop_front();
          reports_seen++;
          if (want.alive) alive_seen++;
          if (want.crit) crit_seen++;
          if (beat_count !== want.count) report_mismatch("beat_count", beat_count, want.count);
          if (last_tick !== want.last) report_mismatch("last_tick", last_tick, want.last);
          if (age_ms !== want.age) report_mismatch("age_ms", age_ms, want.age);
          if (alive !== want.alive)
            report_mismatch("alive", WORD_W'(alive), WORD_W'(want.alive));
          if (all_critical_alive !== want.crit)
            report_mismatch("all_critical_alive", WORD_W'(all_critical_alive),
                            WORD_W'(want.crit));
        end
      end
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [WORD_W-1:0] thr);
    hb_item_t it;
    it.op      = op;
    it.ch      = ch;
    it.max_age = thr;
    pending_items.push_back(it);
  endtask

  function automatic logic [WORD_W-1:0] rand_threshold();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5) return $urandom_range(0, 40);
    if (k < 7) return $urandom;
    if (k == 7) return '0;
    if (k == 8) return '1;
    return $urandom_range(0, 1000);
  endfunction

  // mostly ticks and beats on the critical channels, some noise
  task automatic fill_random(input int n);
    int made;
    int unsigned pick;
    int unsigned run;
    logic [CH_W-1:0] ch;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        run = $urandom_range(5, 25);
        repeat (run) push_item(OP_TICK, CH_W'($urandom_range(0, 7)), rand_threshold());
        made += run;
      end else begin
        if (pick < 35) begin
          push_item(OP_TICK, CH_W'($urandom_range(0, 7)), rand_threshold());
        end else if (pick < 70) begin
          ch = ($urandom_range(0, 4) != 0) ? CH_W'($urandom_range(1, 4))
                                           : CH_W'($urandom_range(0, 7));
          push_item(OP_BEAT, ch, rand_threshold());
        end else if (pick < 95) begin
          push_item(OP_QUERY, CH_W'($urandom_range(0, 7)), rand_threshold());
        end else begin
          push_item(OP_SPARE, CH_W'($urandom_range(0, 7)), rand_threshold());
        end
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    crit_limit[idx] = val;
  endtask

  task automatic write_limits(input logic [LIMIT_W-1:0] motor, input logic [LIMIT_W-1:0] host,
                              input logic [LIMIT_W-1:0] dbg, input logic [LIMIT_W-1:0] status);
    write_limit(REG_LIMIT_MOTOR, motor);
    write_limit(REG_LIMIT_HOST, host);
    write_limit(REG_LIMIT_DEBUG, dbg);
    write_limit(REG_LIMIT_STATUS, status);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      ch_beats[c] = '0;
      ch_stamp[c] = '0;
    end
    for (int c = 0; c < CRIT_COUNT; c++) crit_limit[c] = LIMIT_RESET[c];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, limits at their reset values
    push_item(OP_QUERY, 3'd1, '1);
    push_item(OP_BEAT,  3'd1, '1);            // stamped at tick zero: still never beaten
    push_item(OP_BEAT,  3'd7, '1);            // unknown channel, ignored
    push_item(OP_QUERY, 3'd5, '1);
    push_item(OP_SPARE, 3'd2, '0);
    push_item(OP_TICK,  3'd0, '0);
    push_item(OP_BEAT,  3'd1, '0);
    push_item(OP_BEAT,  3'd2, 32'd1);
    push_item(OP_BEAT,  3'd3, 32'd5);
    push_item(OP_BEAT,  3'd4, '1);
    push_item(OP_TICK,  3'd3, '0);
    push_item(OP_TICK,  3'd6, '1);
    push_item(OP_QUERY, 3'd1, 32'd1);
    push_item(OP_QUERY, 3'd1, 32'd2);
    push_item(OP_BEAT,  3'd0, 32'h8000_0000);
    push_item(OP_QUERY, 3'd0, '0);
    push_item(OP_TICK,  3'd4, 32'hFFFF_FFFE);
    push_item(OP_QUERY, 3'd4, 32'h7FFF_FFFF);
    push_item(OP_BEAT,  3'd5, 32'h5555_AAAA);
    push_item(OP_SPARE, 3'd7, 32'hAAAA_5555);
    wait_drained();

    // random phases, each under its own set of limits
    write_limits('0, '0, '0, '0);
    fill_random(PHASE_ITEMS);
    wait_drained();
    write_limits(16'd3, 16'd5, 16'd8, 16'd12);
    fill_random(PHASE_ITEMS);
    wait_drained();
    write_limits('1, '1, '1, '1);
    fill_random(PHASE_ITEMS);
    wait_drained();
    write_limits(16'd1, '1, '0, 16'd20);
    fill_random(PHASE_ITEMS);
    wait_drained();
    write_limits(16'd200, 16'd200, 16'd500, 16'd500);
    fill_random(PHASE_ITEMS);
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Ran %0d items over 5 limit settings, %0d ticks; %0d reports checked.",
             items_sent, tick_count, reports_seen);
    $display("%0d reports alive, %0d with all critical channels alive, %0d mismatches.",
             alive_seen, crit_seen, error_count);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("** multi_channel_heartbeat_monitor: PASSED **");
    end else begin
      $display("** multi_channel_heartbeat_monitor: FAILED **");
    end
    $finish;
  end

  initial begin
    #(200_000 * 12);
    $display("Timed out with %0d items pending, %0d reports outstanding.",
             pending_items.size(), expected_reports.size());
    $display("** multi_channel_heartbeat_monitor: FAILED **");
    $finish;
  end

endmodule
